// ----- hdl/icp_pkg.sv -----
// Package for the in-circle predicate pipeline: coordinate and product widths,
// the split points of the wide multiplies, and the orientation codes.
// No dependencies; imported by incircle_predicate, incircle_checker and tb.
package icp_pkg;

    // Coordinate width of every input field.
    localparam int COORD_BITS = 16;

    // Derived widths, all signed two's complement.
    localparam int CW   = COORD_BITS;        // input coordinate
    localparam int DW   = CW + 1;            // coordinate difference
    localparam int PW   = 2 * DW;            // product of two differences
    localparam int LW   = PW + 1;            // lifted term x*x + y*y
    localparam int M3W  = PW + 1;            // 2x2 minor of differences
    localparam int QW   = DW + LW;           // difference times lifted term
    localparam int M1W  = QW + 1;            // 2x2 minor with a lifted column
    localparam int TW   = DW + M1W;          // one cofactor term of the 3x3
    localparam int DETW = TW + 2;            // sum of three cofactor terms

    // Split points of the wide multiplies; low halves are unsigned.
    localparam int LO1  = M1W / 2;
    localparam int LO3  = M3W / 2;
    localparam int P1LW = DW + LO1 + 1;      // diff x low half of M1-type minor
    localparam int P1HW = DW + M1W - LO1;    // diff x high half
    localparam int P3LW = LW + LO3 + 1;      // lifted x low half of M3 minor
    localparam int P3HW = LW + M3W - LO3;    // lifted x high half

    // Pipeline depth including the output register.
    localparam int NSTG = 9;

    typedef enum logic [1:0] {
        ORI_COLLINEAR = 2'd0,
        ORI_CW        = 2'd1,
        ORI_CCW       = 2'd2
    } t_orient;

endpackage

// ----- hdl/incircle_predicate.sv -----
// Delaunay in-circle predicate: nine-stage pipeline with exact integer arithmetic.
// Depends on icp_pkg (widths, split points, orientation codes).
//
// Usage
//   Input channel : i_in_valid / o_in_ready carry one item, a query point and
//                   three triangle vertices as signed COORD_BITS-bit coordinates.
//   Output channel: o_out_valid / i_out_ready carry one item per input item,
//                   o_inside_circle (determinant strictly positive) and
//                   o_tri_orientation (0 collinear, 1 clockwise, 2 counterclockwise,
//                   for the vertices in the order given).
//   Path          : the accepting edge loads stage 1 of nine; the item then moves
//                   through stages 2 to 9; o_out_valid marks it in stage 9.
//   Throughput    : one item per cycle unless stalled; each stage holds at most
//                   one item; depth follows the multiply chain (differences, squares,
//                   lifted minors, split cofactor products, final sum).
//   Stall         : the whole pipeline advances together; when the output
//                   register holds an item that is not taken, every stage holds
//                   and o_in_ready drops. Bubbles in the pipe still move forward
//                   only with the rest, so nothing is lost or repeated.
//   Reset         : i_rst_n low at a clock edge clears all valid bits; payload
//                   registers keep whatever they hold.
//   Swap          : unless the orientation is counterclockwise, vertices 1 and 2
//                   trade places before the determinant; the swap is applied in
//                   stage 3, where the orientation code becomes known.
module incircle_predicate
    import icp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [CW-1:0]  i_query_x,
    input  logic signed [CW-1:0]  i_query_y,
    input  logic signed [CW-1:0]  i_vert1_x,
    input  logic signed [CW-1:0]  i_vert1_y,
    input  logic signed [CW-1:0]  i_vert2_x,
    input  logic signed [CW-1:0]  i_vert2_y,
    input  logic signed [CW-1:0]  i_vert3_x,
    input  logic signed [CW-1:0]  i_vert3_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_inside_circle,
    output logic [1:0]            o_tri_orientation
);

    // Global advance: move everything when the output slot is free or taken.
    logic            w_en;
    logic            w_in_fire;
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_v;

    assign w_en      = !r_v[NSTG-1] || i_out_ready;
    assign w_in_fire = i_in_valid && w_en;
    assign n_v       = {r_v[NSTG-2:0], w_in_fire};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= n_v;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: translate vertices by -P and form orientation differences.
    // a = V1-P and b = V2-P are kept unswapped here.
    // ---------------------------------------------------------------------
    logic signed [DW-1:0] n1_ax, n1_ay, n1_bx, n1_by, n1_cx, n1_cy;
    logic signed [DW-1:0] n1_d1, n1_d2, n1_d3, n1_d4;
    logic signed [DW-1:0] r1_ax, r1_ay, r1_bx, r1_by, r1_cx, r1_cy;
    logic signed [DW-1:0] r1_d1, r1_d2, r1_d3, r1_d4;

    always_comb begin
        n1_ax = DW'(i_vert1_x) - DW'(i_query_x);
        n1_ay = DW'(i_vert1_y) - DW'(i_query_y);
        n1_bx = DW'(i_vert2_x) - DW'(i_query_x);
        n1_by = DW'(i_vert2_y) - DW'(i_query_y);
        n1_cx = DW'(i_vert3_x) - DW'(i_query_x);
        n1_cy = DW'(i_vert3_y) - DW'(i_query_y);
        n1_d1 = DW'(i_vert2_y) - DW'(i_vert1_y);
        n1_d2 = DW'(i_vert3_x) - DW'(i_vert2_x);
        n1_d3 = DW'(i_vert3_y) - DW'(i_vert2_y);
        n1_d4 = DW'(i_vert2_x) - DW'(i_vert1_x);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax <= n1_ax;
            r1_ay <= n1_ay;
            r1_bx <= n1_bx;
            r1_by <= n1_by;
            r1_cx <= n1_cx;
            r1_cy <= n1_cy;
            r1_d1 <= n1_d1;
            r1_d2 <= n1_d2;
            r1_d3 <= n1_d3;
            r1_d4 <= n1_d4;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: all narrow products. Both cross products for the c-minor are
    // formed (with a and with b) so the swap can pick one in stage 3.
    // ---------------------------------------------------------------------
    logic signed [PW-1:0] r2_sax, r2_say, r2_sbx, r2_sby, r2_scx, r2_scy;
    logic signed [PW-1:0] r2_o1, r2_o2;
    logic signed [PW-1:0] r2_axcy, r2_aycx, r2_bxcy, r2_bycx;
    logic signed [DW-1:0] r2_ax, r2_ay, r2_bx, r2_by, r2_cx, r2_cy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sax  <= PW'(r1_ax) * PW'(r1_ax);
            r2_say  <= PW'(r1_ay) * PW'(r1_ay);
            r2_sbx  <= PW'(r1_bx) * PW'(r1_bx);
            r2_sby  <= PW'(r1_by) * PW'(r1_by);
            r2_scx  <= PW'(r1_cx) * PW'(r1_cx);
            r2_scy  <= PW'(r1_cy) * PW'(r1_cy);
            r2_o1   <= PW'(r1_d1) * PW'(r1_d2);
            r2_o2   <= PW'(r1_d3) * PW'(r1_d4);
            r2_axcy <= PW'(r1_ax) * PW'(r1_cy);
            r2_aycx <= PW'(r1_ay) * PW'(r1_cx);
            r2_bxcy <= PW'(r1_bx) * PW'(r1_cy);
            r2_bycx <= PW'(r1_by) * PW'(r1_cx);
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: orientation code, swap, lifted terms, and the c-minor m3.
    // ---------------------------------------------------------------------
    logic signed [PW:0]   n3_val;
    t_orient              n3_code;
    logic                 n3_swap;
    logic signed [LW-1:0] n3_la_raw, n3_lb_raw, n3_lc;
    logic signed [M3W-1:0] n3_m3_ab, n3_m3_ba;

    t_orient               r3_code;
    logic signed [DW-1:0]  r3_ax, r3_ay, r3_bx, r3_by, r3_cx, r3_cy;
    logic signed [LW-1:0]  r3_la, r3_lb, r3_lc;
    logic signed [M3W-1:0] r3_m3;

    always_comb begin
        n3_val = (PW + 1)'(r2_o1) - (PW + 1)'(r2_o2);
        if (n3_val == '0) begin
            n3_code = ORI_COLLINEAR;
        end else if (!n3_val[PW]) begin
            n3_code = ORI_CW;
        end else begin
            n3_code = ORI_CCW;
        end
        n3_swap   = (n3_code != ORI_CCW);
        n3_la_raw = LW'(r2_sax) + LW'(r2_say);
        n3_lb_raw = LW'(r2_sbx) + LW'(r2_sby);
        n3_lc     = LW'(r2_scx) + LW'(r2_scy);
        // m3 = bx*cy - by*cx with b = V2-P (no swap) or b = V1-P (swap)
        n3_m3_ab  = M3W'(r2_bxcy) - M3W'(r2_bycx);
        n3_m3_ba  = M3W'(r2_axcy) - M3W'(r2_aycx);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_code <= n3_code;
            r3_cx   <= r2_cx;
            r3_cy   <= r2_cy;
            r3_lc   <= n3_lc;
            if (n3_swap) begin
                r3_ax <= r2_bx;
                r3_ay <= r2_by;
                r3_bx <= r2_ax;
                r3_by <= r2_ay;
                r3_la <= n3_lb_raw;
                r3_lb <= n3_la_raw;
                r3_m3 <= n3_m3_ba;
            end else begin
                r3_ax <= r2_ax;
                r3_ay <= r2_ay;
                r3_bx <= r2_bx;
                r3_by <= r2_by;
                r3_la <= n3_la_raw;
                r3_lb <= n3_lb_raw;
                r3_m3 <= n3_m3_ab;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: products of differences with lifted terms.
    // ---------------------------------------------------------------------
    logic signed [QW-1:0]  r4_q1, r4_q2, r4_q3, r4_q4;
    logic signed [DW-1:0]  r4_ax, r4_ay;
    logic signed [LW-1:0]  r4_la;
    logic signed [M3W-1:0] r4_m3;
    t_orient               r4_code;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_q1   <= QW'(r3_by) * QW'(r3_lc);
            r4_q2   <= QW'(r3_lb) * QW'(r3_cy);
            r4_q3   <= QW'(r3_bx) * QW'(r3_lc);
            r4_q4   <= QW'(r3_lb) * QW'(r3_cx);
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            r4_la   <= r3_la;
            r4_m3   <= r3_m3;
            r4_code <= r3_code;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: lifted minors m1 = by*lc - lb*cy, m2 = bx*lc - lb*cx.
    // ---------------------------------------------------------------------
    logic signed [M1W-1:0] r5_m1, r5_m2;
    logic signed [DW-1:0]  r5_ax, r5_ay;
    logic signed [LW-1:0]  r5_la;
    logic signed [M3W-1:0] r5_m3;
    t_orient               r5_code;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_m1   <= M1W'(r4_q1) - M1W'(r4_q2);
            r5_m2   <= M1W'(r4_q3) - M1W'(r4_q4);
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
            r5_la   <= r4_la;
            r5_m3   <= r4_m3;
            r5_code <= r4_code;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 6: cofactor products, each split at the minor's midpoint:
    // unsigned low half, signed high half.
    // ---------------------------------------------------------------------
    logic signed [P1LW-1:0] r6_p1lo, r6_p2lo;
    logic signed [P1HW-1:0] r6_p1hi, r6_p2hi;
    logic signed [P3LW-1:0] r6_p3lo;
    logic signed [P3HW-1:0] r6_p3hi;
    t_orient                r6_code;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_p1lo <= P1LW'(r5_ax) * P1LW'($signed({1'b0, r5_m1[LO1-1:0]}));
            r6_p1hi <= P1HW'(r5_ax) * P1HW'($signed(r5_m1[M1W-1:LO1]));
            r6_p2lo <= P1LW'(r5_ay) * P1LW'($signed({1'b0, r5_m2[LO1-1:0]}));
            r6_p2hi <= P1HW'(r5_ay) * P1HW'($signed(r5_m2[M1W-1:LO1]));
            r6_p3lo <= P3LW'(r5_la) * P3LW'($signed({1'b0, r5_m3[LO3-1:0]}));
            r6_p3hi <= P3HW'(r5_la) * P3HW'($signed(r5_m3[M3W-1:LO3]));
            r6_code <= r5_code;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 7: recombine halves into the three cofactor terms.
    // ---------------------------------------------------------------------
    logic signed [TW-1:0] r7_t1, r7_t2, r7_t3;
    t_orient              r7_code;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_t1   <= (TW'(r6_p1hi) <<< LO1) + TW'(r6_p1lo);
            r7_t2   <= (TW'(r6_p2hi) <<< LO1) + TW'(r6_p2lo);
            r7_t3   <= (TW'(r6_p3hi) <<< LO3) + TW'(r6_p3lo);
            r7_code <= r6_code;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 8: determinant = ax*m1 - ay*m2 + la*m3.
    // ---------------------------------------------------------------------
    logic signed [DETW-1:0] r8_det;
    t_orient                r8_code;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_det  <= DETW'(r7_t1) - DETW'(r7_t2) + DETW'(r7_t3);
            r8_code <= r7_code;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 9: output register; inside when strictly positive.
    // ---------------------------------------------------------------------
    logic    r9_inside;
    t_orient r9_code;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_inside <= !r8_det[DETW-1] && (r8_det != '0);
            r9_code   <= r8_code;
        end
    end

    assign o_in_ready        = w_en;
    assign o_out_valid       = r_v[NSTG-1];
    assign o_inside_circle   = r9_inside;
    assign o_tri_orientation = r9_code;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // A result appears only from an item that sat in the last compute stage.
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v[NSTG-2]))
        else $error("output valid rose without an item in stage 8");

    // While the output is stalled, the determinant stage holds its item.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_v[NSTG-2]) |=> ($stable(r8_det) && r_v[NSTG-2]))
        else $error("stage 8 changed during a stall");

    // An empty output slot always lets a new item in.
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked while output slot is empty");

endmodule

// ----- dv/incircle_checker.sv -----
`timescale 1ns / 1ps
// Checker for incircle_predicate: watches both channels and predicts each result.
// Depends on icp_pkg for the coordinate width and the orientation codes.
module incircle_checker
    import icp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic signed [CW-1:0] i_query_x,
    input  logic signed [CW-1:0] i_query_y,
    input  logic signed [CW-1:0] i_vert1_x,
    input  logic signed [CW-1:0] i_vert1_y,
    input  logic signed [CW-1:0] i_vert2_x,
    input  logic signed [CW-1:0] i_vert2_y,
    input  logic signed [CW-1:0] i_vert3_x,
    input  logic signed [CW-1:0] i_vert3_y,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_inside_circle,
    input  logic [1:0]           i_tri_orientation,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic    in_circle;
        t_orient orient;
    } t_verdict;

    t_verdict verdict_q [$];

    // Exact in-circle verdict; 128-bit signed math leaves plenty of headroom.
    function automatic t_verdict incircle_verdict(
        input logic signed [CW-1:0] px, py, x1, y1, x2, y2, x3, y3
    );
        logic signed [127:0] v1x, v1y, v2x, v2y, v3x, v3y, turn, tx, ty;
        logic signed [127:0] ax, ay, bx, by, cx, cy, la, lb, lc, m1, m2, m3, det;
        t_verdict r;
        v1x = 128'(x1); v1y = 128'(y1);
        v2x = 128'(x2); v2y = 128'(y2);
        v3x = 128'(x3); v3y = 128'(y3);
        turn = (v2y - v1y) * (v3x - v2x) - (v3y - v2y) * (v2x - v1x);
        if (turn == 0)
            r.orient = ORI_COLLINEAR;
        else if (turn > 0)
            r.orient = ORI_CW;
        else
            r.orient = ORI_CCW;
        // make the triangle counterclockwise before the lifted determinant
        if (r.orient != ORI_CCW) begin
            tx = v1x; ty = v1y;
            v1x = v2x; v1y = v2y;
            v2x = tx; v2y = ty;
        end
        ax = v1x - 128'(px); ay = v1y - 128'(py);
        bx = v2x - 128'(px); by = v2y - 128'(py);
        cx = v3x - 128'(px); cy = v3y - 128'(py);
        la = ax * ax + ay * ay;
        lb = bx * bx + by * by;
        lc = cx * cx + cy * cy;
        m1 = by * lc - lb * cy;
        m2 = bx * lc - lb * cx;
        m3 = bx * cy - by * cx;
        det = ax * m1 - ay * m2 + la * m3;
        r.in_circle = (det > 0);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict want;
        t_verdict fresh;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            verdict_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                fresh = incircle_verdict(i_query_x, i_query_y,
                                         i_vert1_x, i_vert1_y,
                                         i_vert2_x, i_vert2_y,
                                         i_vert3_x, i_vert3_y);
                verdict_q.insert(verdict_q.size(), fresh);
            end
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result with no item pending: inside_circle=%0d tri_orientation=%0d",
                           i_inside_circle, i_tri_orientation);
                    errs++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_inside_circle !== want.in_circle) begin
                        $error("inside_circle: expected %0d, got %0d",
                               want.in_circle, i_inside_circle);
                        errs++;
                    end
                    if (i_tri_orientation !== want.orient) begin
                        $error("tri_orientation: expected %0d, got %0d",
                               want.orient, i_tri_orientation);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= verdict_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Top of the incircle_predicate bench: clock, reset, item stimulus and verdict.
// Depends on icp_pkg, incircle_predicate and incircle_checker.
module tb
    import icp_pkg::*;
();

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [CW-1:0] i_query_x, i_query_y;
    logic signed [CW-1:0] i_vert1_x, i_vert1_y;
    logic signed [CW-1:0] i_vert2_x, i_vert2_y;
    logic signed [CW-1:0] i_vert3_x, i_vert3_y;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_inside_circle;
    logic [1:0]           o_tri_orientation;

    int fail_count;
    int pending;

    // Idle limits for each side; zero gives back-to-back stretches.
    int tx_gap_max = 14;
    int rx_gap_max = 14;
    // Bumped by the sender to make the receiver hold off for a long stretch.
    int rx_hold_count = 0;

    incircle_predicate DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_query_x         (i_query_x),
        .i_query_y         (i_query_y),
        .i_vert1_x         (i_vert1_x),
        .i_vert1_y         (i_vert1_y),
        .i_vert2_x         (i_vert2_x),
        .i_vert2_y         (i_vert2_y),
        .i_vert3_x         (i_vert3_x),
        .i_vert3_y         (i_vert3_y),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_inside_circle   (o_inside_circle),
        .o_tri_orientation (o_tri_orientation)
    );

    incircle_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_query_x         (i_query_x),
        .i_query_y         (i_query_y),
        .i_vert1_x         (i_vert1_x),
        .i_vert1_y         (i_vert1_y),
        .i_vert2_x         (i_vert2_x),
        .i_vert2_y         (i_vert2_y),
        .i_vert3_x         (i_vert3_x),
        .i_vert3_y         (i_vert3_y),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_inside_circle   (o_inside_circle),
        .i_tri_orientation (o_tri_orientation),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offer one item: idle for a random number of cycles, then hold valid and
    // the payload until the handshake completes. Valid stays high straight into
    // the next item when that item draws no idle cycles.
    task automatic send_item(input int qx, qy, ax, ay, bx, by, cx, cy);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_query_x  <= CW'(qx);
        i_query_y  <= CW'(qy);
        i_vert1_x  <= CW'(ax);
        i_vert1_y  <= CW'(ay);
        i_vert2_x  <= CW'(bx);
        i_vert2_y  <= CW'(by);
        i_vert3_x  <= CW'(cx);
        i_vert3_y  <= CW'(cy);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and hold off the next item until every predicted result is back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One random item. The mix leans on the hard cases: collinear vertices,
    // small grids where ties are common, and four points on one circle where
    // the determinant is exactly zero unless the query is nudged off it.
    task automatic send_random();
        int sel, ox, oy, k, step, q, b, rx, ry, t, nudge;
        int pick [12];
        int ptx [4];
        int pty [4];
        int c [8];
        sel = $urandom_range(0, 9);
        if (sel <= 3) begin
            for (int i = 0; i < 8; i++) c[i] = $urandom();
        end else if (sel <= 5) begin
            for (int i = 0; i < 8; i++) c[i] = $urandom_range(0, 16) - 8;
        end else if (sel <= 7) begin
            // points of radius 5k: (3,4), (4,3), (5,0) turned by quarter turns
            ox = $urandom_range(0, 10000) - 5000;
            oy = $urandom_range(0, 10000) - 5000;
            k  = $urandom_range(1, 5000);
            for (int i = 0; i < 12; i++) pick[i] = i;
            for (int i = 0; i < 4; i++) begin
                step = $urandom_range(i, 11);
                t = pick[i]; pick[i] = pick[step]; pick[step] = t;
            end
            for (int i = 0; i < 4; i++) begin
                q = pick[i] / 3;
                b = pick[i] % 3;
                rx = (b == 0) ? 3 : (b == 1) ? 4 : 5;
                ry = (b == 0) ? 4 : (b == 1) ? 3 : 0;
                for (int j = 0; j < q; j++) begin
                    t = rx; rx = ry; ry = -t;
                end
                ptx[i] = ox + k * rx;
                pty[i] = oy + k * ry;
            end
            nudge = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2) - 1 : 0;
            c[0] = ptx[0] + nudge; c[1] = pty[0];
            c[2] = ptx[1]; c[3] = pty[1];
            c[4] = ptx[2]; c[5] = pty[2];
            c[6] = ptx[3]; c[7] = pty[3];
        end else if (sel == 8) begin
            // collinear vertices on a random line, query anywhere
            ox = $urandom_range(0, 20000) - 10000;
            oy = $urandom_range(0, 20000) - 10000;
            rx = $urandom_range(0, 2000) - 1000;
            ry = $urandom_range(0, 2000) - 1000;
            c[0] = $urandom(); c[1] = $urandom();
            for (int i = 1; i < 4; i++) begin
                t = $urandom_range(0, 20) - 10;
                c[2 * i]     = ox + t * rx;
                c[2 * i + 1] = oy + t * ry;
            end
        end else begin
            // coordinates drawn from the edges of the range
            for (int i = 0; i < 8; i++) begin
                case ($urandom_range(0, 5))
                    0: c[i] = -32768;
                    1: c[i] = 32767;
                    2: c[i] = 0;
                    3: c[i] = -1;
                    4: c[i] = 1;
                    default: c[i] = $urandom();
                endcase
            end
        end
        send_item(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    // Receiver: draw a stall per item, keep ready high until a result is
    // taken. A hold request stalls it for a long stretch so the pipe fills.
    initial begin : receiver
        int stall;
        int served;
        served = 0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (rx_hold_count != served) begin
                stall  = 250;
                served = rx_hold_count;
            end else begin
                stall = $urandom_range(0, rx_gap_max);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_query_x   <= '0;
        i_query_y   <= '0;
        i_vert1_x   <= '0;
        i_vert1_y   <= '0;
        i_vert2_x   <= '0;
        i_vert2_y   <= '0;
        i_vert3_x   <= '0;
        i_vert3_y   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: degenerate triangles, each orientation, on/in/out of the
        // circle, and coordinates at the ends of the range.
        send_item(0, 0, 0, 0, 0, 0, 0, 0);
        send_item(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_item(1, 1, 0, 0, 10, 0, 0, 10);
        send_item(1, 1, 0, 0, 0, 10, 10, 0);
        send_item(100, 100, 0, 0, 10, 0, 0, 10);
        send_item(10, 10, 0, 0, 10, 0, 0, 10);
        send_item(10, 10, 10, 0, 0, 0, 0, 10);
        send_item(5, -3, 0, 0, 1, 1, 2, 2);
        send_item(0, 0, 7, 7, 7, 7, -3, 2);
        send_item(0, 0, -32768, -32768, 32767, -32768, 32767, 32767);
        send_item(-32768, 32767, -32768, -32768, 32767, -32768, 32767, 32767);
        send_item(0, 0, 32767, -32768, -32768, -32768, 32767, 32767);
        send_item(32767, 32767, -32768, -32768, 32767, -32768, 32767, 32767);
        send_item(-32768, 32767, -32768, -32768, 32767, 32767, 32767, 32766);
        send_item(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846);
        send_item(-21846, 21845, 21845, -21846, -21846, -21846, 21845, 21845);
        send_item(-1, -1, 32767, 0, 0, 32767, -32768, 0);

        // Pause the sender until the directed results are all back.
        drain_results();

        for (int i = 0; i < 400; i++) send_random();

        // Back-to-back on both sides while the receiver holds off: the pipe
        // fills and the input stalls, then drains at full rate.
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_count++;
        for (int i = 0; i < 150; i++) send_random();

        drain_results();

        tx_gap_max = 14;
        for (int i = 0; i < 150; i++) send_random();
        tx_gap_max = 0;
        rx_gap_max = 14;
        for (int i = 0; i < 200; i++) send_random();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[incircle_predicate] OK");
        else
            $display("[incircle_predicate] ERROR");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("[incircle_predicate] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/icp_pkg.sv
hdl/incircle_predicate.sv
dv/incircle_checker.sv
dv/tb.sv
